[src/alr_pkg.sv]
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the antialiased line rasterizer
// Widths, codes and the command format passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package alr_pkg;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 24;
  localparam int WEIGHT_BITS = 8;
  localparam int WALK_BITS   = COORD_BITS + FRAC_BITS;
  localparam int SPAN_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS    = SPAN_BITS + 1;
  localparam int STEP_BITS   = FRAC_BITS + 1;
  localparam int OPA_BITS    = 9;
  localparam int CNT_BITS    = $clog2(FRAC_BITS + 1);
  localparam int ADDR_BITS   = 3;
  localparam logic [OPA_BITS-1:0] FULL_OPACITY = OPA_BITS'(1 << WEIGHT_BITS);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;
  localparam logic REG_LINE_MODE = 1'b0;
  localparam logic MODE_STEPPER  = 1'b1;

  typedef enum logic [1:0] {
    KIND_STEP = 2'd0,
    KIND_WU_X = 2'd1,
    KIND_WU_Y = 2'd2
  } kind_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  is_start;
    coord_t                x1;
    coord_t                y1;
    coord_t                x2;
    coord_t                y2;
    logic [OPA_BITS-1:0]   op;
    kind_t                 kind;
    logic [SPAN_BITS-1:0]  span_x;
    logic [SPAN_BITS-1:0]  span_y;
    logic [STEP_BITS-1:0]  minor_step;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;
endpackage
`default_nettype wire

[src/alr_in_if.sv]
// ----------------------------------------------------------------------------
// alr_in_if: input channel of the line rasterizer
// Valid/ready channel carrying one action with its endpoints and opacity.
// ----------------------------------------------------------------------------
`default_nettype none
interface alr_in_if;
  import alr_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  coord_t              x_start;
  coord_t              y_start;
  coord_t              x_end;
  coord_t              y_end;
  logic [OPA_BITS-1:0] opacity;
  modport source (output valid, action, x_start, y_start, x_end, y_end, opacity,
                  input ready);
  modport sink (input valid, action, x_start, y_start, x_end, y_end, opacity,
                output ready);
endinterface
`default_nettype wire

[src/alr_out_if.sv]
// ----------------------------------------------------------------------------
// alr_out_if: pixel channel of the line rasterizer
// Valid/ready channel carrying one pixel or vertical pixel pair.
// ----------------------------------------------------------------------------
`default_nettype none
interface alr_out_if;
  import alr_pkg::*;
  logic                valid;
  logic                ready;
  coord_t              pixel_x;
  coord_t              pixel_y;
  logic [OPA_BITS-1:0] weight_first;
  logic [OPA_BITS-1:0] weight_second;
  logic                pair_used;
  logic                line_last;
  modport source (output valid, pixel_x, pixel_y, weight_first, weight_second,
                  pair_used, line_last, input ready);
  modport sink (input valid, pixel_x, pixel_y, weight_first, weight_second,
                pair_used, line_last, output ready);
endinterface
`default_nettype wire

[src/antialiased_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: Wu-style antialiased line generator
// Front classifier with serial slope divider, command queue, pixel walker.
// ----------------------------------------------------------------------------
// A start transfer loads a line and yields no pixel; each tick transfer then
// yields one pixel (or vertical pair) until the end point is reached. Ticks
// are handled at one per clock unless the queue is full or the output stalls.
// A start of an antialiased (non-straight) line holds the input while the
// serial restoring divider in the front computes the minor step and hands
// the load command to the queue; other starts go to the queue directly.
// A pixel leaves through a walk stage and a weight multiply stage; the
// output register lets input continue while a pixel waits to be taken.
`default_nettype none
module antialiased_line_rasterizer (
  input  wire logic        clk,
  input  wire logic        rst,
  alr_in_if.sink           in_ch,
  alr_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [alr_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import alr_pkg::*;

  logic       line_mode;
  cmd_t       f_cmd, q_cmd;
  qctl_t      qctl_push;
  logic       q_full, q_valid, q_pop, dividing;
  logic [1:0] q_level;

  // Configuration: the mode register sits at byte address zero.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LINE_MODE) begin
      line_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_LINE_MODE) ? {31'b0, line_mode} : 32'b0;

  alr_front u_front (
    .clk, .rst, .line_mode, .in_ch,
    .cmd(f_cmd), .qctl_push, .q_full, .dividing
  );

  alr_fifo u_fifo (
    .clk, .rst, .qctl_push, .wr_cmd(f_cmd), .full(q_full),
    .not_empty(q_valid), .pop(q_pop), .rd_cmd(q_cmd), .level(q_level)
  );

  alr_back u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .out_ch
  );

  // The queue never holds more than two commands.
  a_level: assert property (@(posedge clk) disable iff (rst) q_level != 2'd3)
    else $error("command queue overfilled");
  // No input is taken while the slope divider runs.
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    dividing |-> !in_ch.ready) else $error("input taken during divide");
  // A single pixel carries no second weight.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.pair_used) |-> out_ch.weight_second == '0)
    else $error("second weight on single pixel");
  // Pair weights never exceed full coverage together.
  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (10'(out_ch.weight_first) + 10'(out_ch.weight_second)
                      <= 10'(FULL_OPACITY)))
    else $error("weights exceed full coverage");
endmodule
`default_nettype wire

[src/alr_front.sv]
// ----------------------------------------------------------------------------
// alr_front: input classification and slope division
// Turns start items into load commands (with a serial divide for Wu lines)
// and forwards ticks.
// ----------------------------------------------------------------------------
`default_nettype none
module alr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          line_mode,
  alr_in_if.sink             in_ch,
  output alr_pkg::cmd_t      cmd,
  output alr_pkg::qctl_t     qctl_push,
  input  wire logic          q_full,
  output logic               dividing
);
  import alr_pkg::*;

  typedef enum logic [1:0] {F_IDLE = 2'b01, F_DIV = 2'b10} fstate_t;

  fstate_t               state, state_next;
  cmd_t                  held;
  logic [SPAN_BITS-1:0]  rem, dvs;
  logic [FRAC_BITS-1:0]  quo;
  logic [CNT_BITS-1:0]   cnt;
  logic                  neg;

  logic signed [SPAN_BITS-1:0] dx, dy;
  logic [SPAN_BITS-1:0]  sx, sy;
  logic [OPA_BITS-1:0]   op_c;
  kind_t                 kind_c;
  cmd_t                  cmd_c;
  logic                  accept;
  logic [SPAN_BITS:0]    trial;
  logic                  div_done;
  logic [STEP_BITS-1:0]  quo_ext;

  always_comb begin
    dx = SPAN_BITS'(in_ch.x_end) - SPAN_BITS'(in_ch.x_start);
    dy = SPAN_BITS'(in_ch.y_end) - SPAN_BITS'(in_ch.y_start);
    sx = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
    sy = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
    op_c = (in_ch.opacity > FULL_OPACITY) ? FULL_OPACITY : in_ch.opacity;
    if (line_mode == MODE_STEPPER || sx == sy || sx == '0 || sy == '0) begin
      kind_c = KIND_STEP;
    end else if (sy < sx) begin
      kind_c = KIND_WU_X;
    end else begin
      kind_c = KIND_WU_Y;
    end
    cmd_c.is_start   = (in_ch.action == ACT_START);
    cmd_c.x1         = in_ch.x_start;
    cmd_c.y1         = in_ch.y_start;
    cmd_c.x2         = in_ch.x_end;
    cmd_c.y2         = in_ch.y_end;
    cmd_c.op         = op_c;
    cmd_c.kind       = kind_c;
    cmd_c.span_x     = sx;
    cmd_c.span_y     = sy;
    cmd_c.minor_step = '0;
  end

  assign in_ch.ready = (state == F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign trial       = {rem, 1'b0};
  assign div_done    = (cnt == CNT_BITS'(FRAC_BITS));
  assign quo_ext     = {1'b0, quo};
  assign dividing    = (state == F_DIV);

  always_comb begin
    state_next     = state;
    cmd            = cmd_c;
    qctl_push.push = 1'b0;
    qctl_push.full = q_full;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (cmd_c.is_start && cmd_c.kind != KIND_STEP) begin
            state_next = F_DIV;
          end else begin
            qctl_push.push = 1'b1;
          end
        end
      end
      F_DIV: begin
        cmd = held;
        cmd.minor_step = neg ? STEP_BITS'(-quo_ext) : quo_ext;
        if (div_done && !q_full) begin
          qctl_push.push = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      held <= cmd_c;
      cnt  <= '0;
      quo  <= '0;
      if (kind_c == KIND_WU_X) begin
        rem <= sy;
        dvs <= sx;
        neg <= dy[SPAN_BITS-1];
      end else begin
        rem <= sx;
        dvs <= sy;
        neg <= dx[SPAN_BITS-1];
      end
    end else if (state == F_DIV && !div_done) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= SPAN_BITS'(trial - {1'b0, dvs});
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[SPAN_BITS-1:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[src/alr_fifo.sv]
// ----------------------------------------------------------------------------
// alr_fifo: two-entry command queue
// Decouples the classifying front from the pixel walking back.
// ----------------------------------------------------------------------------
`default_nettype none
module alr_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire alr_pkg::qctl_t qctl_push,
  input  wire alr_pkg::cmd_t  wr_cmd,
  output logic             full,
  output logic             not_empty,
  input  wire logic        pop,
  output alr_pkg::cmd_t    rd_cmd,
  output logic [1:0]       level
);
  import alr_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = qctl_push.push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_cmd    = mem[rp];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

[src/alr_back.sv]
// ----------------------------------------------------------------------------
// alr_back: line walker and weight stage
// Holds the line state, steps one pixel per tick and computes the weights.
// ----------------------------------------------------------------------------
`default_nettype none
module alr_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire alr_pkg::cmd_t q_cmd,
  output logic             q_pop,
  alr_out_if.source        out_ch
);
  import alr_pkg::*;

  localparam logic [WALK_BITS-1:0] ONE_FX = WALK_BITS'(1) << FRAC_BITS;

  function automatic logic [WALK_BITS-1:0] step_toward(logic [WALK_BITS-1:0] w,
                                                        coord_t t);
    coord_t c;
    c = coord_t'(w[WALK_BITS-1:FRAC_BITS]);
    if (c > t) return w - ONE_FX;
    else if (c < t) return w + ONE_FX;
    else return w;
  endfunction

  logic                 busy;
  kind_t                kind;
  logic [WALK_BITS-1:0] walk_x, walk_y, walk_x_next, walk_y_next;
  logic [STEP_BITS-1:0] minor_step;
  coord_t               target_x, target_y;
  logic [ERR_BITS-1:0]  error_sum, error_sum_next, e1;
  logic [SPAN_BITS-1:0] span_x, span_y;
  logic [OPA_BITS-1:0]  held_opacity;

  logic                 a_valid;
  coord_t               a_x, a_y;
  logic [FRAC_BITS-1:0] a_f;
  logic [OPA_BITS-1:0]  a_op;
  logic                 a_wu, a_last;

  logic                 b_valid;
  logic                 b_load, a_free, tick, emit;
  logic [WALK_BITS-1:0] step_ext;
  coord_t               cx, cy, nx, ny;
  logic                 last_c;
  logic [FRAC_BITS:0]   inv_f;
  logic [OPA_BITS+FRAC_BITS:0] prod_hi;
  logic [OPA_BITS+FRAC_BITS-1:0] prod_lo;

  assign b_load = a_valid && (!b_valid || out_ch.ready);
  assign a_free = !a_valid || b_load;
  assign q_pop  = q_valid && a_free;
  assign tick   = q_pop && !q_cmd.is_start;
  assign emit   = tick && busy;
  assign step_ext = WALK_BITS'(signed'(minor_step));
  assign cx = coord_t'(walk_x[WALK_BITS-1:FRAC_BITS]);
  assign cy = coord_t'(walk_y[WALK_BITS-1:FRAC_BITS]);

  always_comb begin
    walk_x_next    = walk_x;
    walk_y_next    = walk_y;
    error_sum_next = error_sum;
    e1             = error_sum;
    unique case (kind)
      KIND_WU_X: begin
        walk_x_next = step_toward(walk_x, target_x);
        walk_y_next = walk_y + step_ext;
      end
      KIND_WU_Y: begin
        walk_y_next = step_toward(walk_y, target_y);
        walk_x_next = walk_x + step_ext;
      end
      default: begin
        if (!(cx == target_x && cy == target_y)) begin
          if (error_sum < ERR_BITS'(span_x)) begin
            e1 = error_sum + ERR_BITS'(span_y);
            walk_x_next = step_toward(walk_x, target_x);
          end
          if (e1 >= ERR_BITS'(span_x)) begin
            error_sum_next = e1 - ERR_BITS'(span_x);
            walk_y_next = step_toward(walk_y, target_y);
          end else begin
            error_sum_next = e1;
          end
        end
      end
    endcase
    nx = coord_t'(walk_x_next[WALK_BITS-1:FRAC_BITS]);
    ny = coord_t'(walk_y_next[WALK_BITS-1:FRAC_BITS]);
    unique case (kind)
      KIND_WU_X: last_c = (nx == target_x);
      KIND_WU_Y: last_c = (ny == target_y);
      default:   last_c = (nx == target_x) && (ny == target_y);
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_start) begin
      kind         <= q_cmd.kind;
      walk_x       <= {q_cmd.x1, FRAC_BITS'(0)};
      walk_y       <= {q_cmd.y1, FRAC_BITS'(0)};
      minor_step   <= q_cmd.minor_step;
      target_x     <= q_cmd.x2;
      target_y     <= q_cmd.y2;
      error_sum    <= '0;
      span_x       <= q_cmd.span_x;
      span_y       <= q_cmd.span_y;
      held_opacity <= q_cmd.op;
    end else if (emit) begin
      walk_x    <= walk_x_next;
      walk_y    <= walk_y_next;
      error_sum <= error_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop && q_cmd.is_start) begin
      busy <= 1'b1;
    end else if (emit && last_c) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_x    <= nx;
      a_y    <= ny;
      a_f    <= walk_y_next[FRAC_BITS-1:0];
      a_op   <= held_opacity;
      a_wu   <= (kind != KIND_STEP);
      a_last <= last_c;
    end
  end

  assign inv_f   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  assign prod_hi = (OPA_BITS+FRAC_BITS+1)'(a_op) * ((FRAC_BITS+1)'(inv_f - {1'b0, a_f}));
  assign prod_lo = (OPA_BITS+FRAC_BITS)'(a_op) * (OPA_BITS+FRAC_BITS)'(a_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (out_ch.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_ch.pixel_x   <= a_x;
      out_ch.pixel_y   <= a_y;
      out_ch.pair_used <= a_wu;
      out_ch.line_last <= a_last;
      if (a_wu) begin
        out_ch.weight_first  <= prod_hi[OPA_BITS+FRAC_BITS-1:FRAC_BITS];
        out_ch.weight_second <= prod_lo[OPA_BITS+FRAC_BITS-1:FRAC_BITS];
      end else begin
        out_ch.weight_first  <= a_op;
        out_ch.weight_second <= '0;
      end
    end
  end

  assign out_ch.valid = b_valid;
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the antialiased line rasterizer
// A table of directed line starts and ticks comes first. Random lines follow,
// run under four idling phases and both line modes. A built-in pixel walker
// predicts every pixel, and a queue holds the predictions until the block
// delivers them.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import alr_pkg::*;

  localparam logic [ADDR_BITS-1:0] ADDR_LINE_MODE = ADDR_BITS'(4 * REG_LINE_MODE);
  localparam logic [63:0] ONE_FIXED = 64'd1 << FRAC_BITS;

  typedef struct packed {
    coord_t              x;
    coord_t              y;
    logic [OPA_BITS-1:0] w_first;
    logic [OPA_BITS-1:0] w_second;
    logic                pair;
    logic                last;
  } pixel_t;

  // One row of the directed table. When has_pixel is set, the pixel typed
  // in the row is the expectation. Otherwise the walker's own prediction is.
  typedef struct packed {
    logic                action;
    coord_t              x1;
    coord_t              y1;
    coord_t              x2;
    coord_t              y2;
    logic [OPA_BITS-1:0] op;
    logic                has_pixel;
    pixel_t              pix;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  alr_in_if  in_ch ();
  alr_out_if out_ch ();

  antialiased_line_rasterizer i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Generous cap on the whole run, far above the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // Walker state, kept as the block keeps it. The position is fixed point
  // with FRAC_BITS fraction bits, carried in 64 bits.
  logic        walk_busy = 1'b0;
  logic        walk_mode = 1'b0;
  kind_t       walk_kind = KIND_STEP;
  logic [63:0] pos_x = '0, pos_y = '0, slope_step = '0;
  longint      goal_x = 0, goal_y = 0;
  logic [63:0] err_acc = '0, run_x = '0, run_y = '0, line_op = '0;

  pixel_t pixel_queue[$];
  int     failures = 0;
  int     pixels_seen = 0;
  int     lines_started = 0;
  int     items_sent = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;

  function automatic longint pixel_of(logic [63:0] w);
    coord_t c;
    c = w[FRAC_BITS +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic logic [63:0] move_toward(logic [63:0] w, longint goal);
    longint c;
    c = pixel_of(w);
    if (c > goal) return w - ONE_FIXED;
    if (c < goal) return w + ONE_FIXED;
    return w;
  endfunction

  // Advances the walker by one accepted transfer and returns 1 when the
  // transfer yields a pixel, which is then given in pix.
  function automatic logic walk_line(input logic action, input coord_t x1,
                                     input coord_t y1, input coord_t x2,
                                     input coord_t y2, input logic [8:0] op,
                                     output pixel_t pix);
    longint cx, cy;
    logic [63:0] frac, w1, w2;
    logic last;
    pix = '0;
    if (action == ACT_START) begin
      line_op = (op > FULL_OPACITY) ? 64'(FULL_OPACITY) : 64'(op);
      goal_x = x2;
      goal_y = y2;
      run_x = (x1 > x2) ? 64'(longint'(x1) - x2) : 64'(longint'(x2) - x1);
      run_y = (y1 > y2) ? 64'(longint'(y1) - y2) : 64'(longint'(y2) - y1);
      pos_x = 64'(longint'(x1)) << FRAC_BITS;
      pos_y = 64'(longint'(y1)) << FRAC_BITS;
      err_acc = '0;
      slope_step = '0;
      if (walk_mode == MODE_STEPPER || run_x == run_y || run_x == 0 || run_y == 0) begin
        walk_kind = KIND_STEP;
      end else if (run_y < run_x) begin
        walk_kind = KIND_WU_X;
        slope_step = (run_y << FRAC_BITS) / run_x;
        if (y2 < y1) slope_step = 64'd0 - slope_step;
      end else begin
        walk_kind = KIND_WU_Y;
        slope_step = (run_x << FRAC_BITS) / run_y;
        if (x2 < x1) slope_step = 64'd0 - slope_step;
      end
      walk_busy = 1'b1;
      lines_started++;
      return 1'b0;
    end
    if (!walk_busy) return 1'b0;
    if (walk_kind == KIND_STEP) begin
      cx = pixel_of(pos_x);
      cy = pixel_of(pos_y);
      if (!(cx == goal_x && cy == goal_y)) begin
        if (err_acc < run_x) begin
          err_acc += run_y;
          pos_x = move_toward(pos_x, goal_x);
        end
        if (err_acc >= run_x) begin
          err_acc -= run_x;
          pos_y = move_toward(pos_y, goal_y);
        end
        cx = pixel_of(pos_x);
        cy = pixel_of(pos_y);
      end
      w1 = line_op;
      w2 = '0;
      pix.pair = 1'b0;
      last = (cx == goal_x && cy == goal_y);
    end else begin
      if (walk_kind == KIND_WU_X) begin
        pos_x = move_toward(pos_x, goal_x);
        pos_y += slope_step;
      end else begin
        pos_y = move_toward(pos_y, goal_y);
        pos_x += slope_step;
      end
      cx = pixel_of(pos_x);
      cy = pixel_of(pos_y);
      frac = pos_y & (ONE_FIXED - 1);
      w2 = (line_op * frac) >> FRAC_BITS;
      w1 = (line_op * (ONE_FIXED - frac)) >> FRAC_BITS;
      pix.pair = 1'b1;
      last = (walk_kind == KIND_WU_X) ? (cx == goal_x) : (cy == goal_y);
    end
    if (last) walk_busy = 1'b0;
    pix.x = coord_t'(cx);
    pix.y = coord_t'(cy);
    pix.w_first = w1[8:0];
    pix.w_second = w2[8:0];
    pix.last = last;
    return 1'b1;
  endfunction

  // Offers one transfer to the block after a random number of idle cycles,
  // waits for it to be taken, and records the pixel it should yield.
  task automatic send_item(input logic action, input coord_t x1, input coord_t y1,
                           input coord_t x2, input coord_t y2, input logic [8:0] op,
                           input logic has_pixel, input pixel_t typed);
    pixel_t pix;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= action;
    in_ch.x_start <= x1;
    in_ch.y_start <= y1;
    in_ch.x_end   <= x2;
    in_ch.y_end   <= y2;
    in_ch.opacity <= op;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (walk_line(action, x1, y1, x2, y2, op, pix)) begin
      pixel_queue.push_back(has_pixel ? typed : pix);
    end
  endtask

  // A tick carries payload that the block ignores, so it is random.
  task automatic send_tick();
    send_item(ACT_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), 9'($urandom), 1'b0, '0);
  endtask

  // Lets every expected pixel arrive, plus time for a divider that may
  // still be busy on a start, then writes line_mode over the APB port.
  task automatic set_line_mode(input logic mode);
    in_ch.valid <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (40) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LINE_MODE;
    pwdata  <= {$urandom} & ~32'd1 | 32'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    walk_mode = mode;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic coord_t end_near(coord_t s, int d);
    int e;
    e = int'(s) + d;
    if (e > 32767 || e < -32768) e = int'(s) - d;
    return coord_t'(e);
  endfunction

  // Starts one random line and ticks through it. Most lines are short and
  // are walked to their end. A few span the full coordinate range or are cut
  // off by the next start, which exercises a restart while busy.
  task automatic random_line();
    coord_t x1, y1, x2, y2;
    int pick, reach, cap;
    pick = $urandom_range(99);
    x1 = coord_t'($urandom);
    y1 = coord_t'($urandom);
    reach = (pick < 90) ? 12 : 300;
    x2 = end_near(x1, $urandom_range(0, 2 * reach) - reach);
    y2 = end_near(y1, $urandom_range(0, 2 * reach) - reach);
    cap = 100000;
    if (pick >= 98) begin
      x2 = coord_t'($urandom);
      y2 = coord_t'($urandom);
      cap = $urandom_range(1, 15);
    end else if ($urandom_range(9) == 0) begin
      cap = $urandom_range(0, 5);
    end
    send_item(ACT_START, x1, y1, x2, y2, 9'($urandom), 1'b0, '0);
    while (walk_busy && cap > 0) begin
      send_tick();
      cap--;
    end
  endtask

  function automatic void check_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      failures++;
    end
  endfunction

  // Pixel side: checks each transfer against the oldest expectation and
  // stalls at random.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      pixels_seen++;
      if (pixel_queue.size() == 0) begin
        $error("pixel (%0d,%0d) arrived with none expected", out_ch.pixel_x,
               out_ch.pixel_y);
        failures++;
      end else begin
        want = pixel_queue.pop_front();
        check_field("pixel_x", want.x, out_ch.pixel_x);
        check_field("pixel_y", want.y, out_ch.pixel_y);
        check_field("weight_first", want.w_first, out_ch.weight_first);
        check_field("weight_second", want.w_second, out_ch.weight_second);
        check_field("pair_used", want.pair, out_ch.pair_used);
        check_field("line_last", want.last, out_ch.line_last);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Directed table: idle tick, single point at the coordinate extremes,
  // clamped opacity, horizontal, vertical with zero opacity, diagonal at
  // the extremes, an x-major line cut off by a y-major line, idle tick.
  plan_row_t plan [21] = '{
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_START, -32768, 32767, -32768, 32767, 256, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{-32768, 32767, 256, 0, 1'b0, 1'b1}},
    '{ACT_START, 0, 0, 3, 0, 300, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{1, 0, 256, 0, 1'b0, 1'b0}},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{2, 0, 256, 0, 1'b0, 1'b0}},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{3, 0, 256, 0, 1'b0, 1'b1}},
    '{ACT_START, 5, 5, 5, 3, 0, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{5, 4, 0, 0, 1'b0, 1'b0}},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{5, 3, 0, 0, 1'b0, 1'b1}},
    '{ACT_START, 32767, -32768, 32765, -32766, 511, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{32766, -32767, 256, 0, 1'b0, 1'b0}},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b1, '{32765, -32766, 256, 0, 1'b0, 1'b1}},
    '{ACT_START, 0, 0, 4, 1, 256, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_START, 0, 0, -1, -3, 255, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0},
    '{ACT_TICK,  0, 0, 0, 0, 0, 1'b0, '0}
  };

  initial begin
    int phase_items;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_TICK;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.x_end   = '0;
    in_ch.y_end   = '0;
    in_ch.opacity = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      send_item(plan[i].action, plan[i].x1, plan[i].y1, plan[i].x2, plan[i].y2,
                plan[i].op, plan[i].has_pixel, plan[i].pix);
    end

    // Four idling phases: none, sender idle, receiver stalling, both. The
    // line mode alternates: Wu meets none and stalling, stepper the others.
    for (int phase = 0; phase < 8; phase++) begin
      idle_pct  = (phase[1:0] == 2'd1) ? 76 : (phase[1:0] == 2'd3) ? 38 : 0;
      stall_pct = (phase[1:0] == 2'd2) ? 76 : (phase[1:0] == 2'd3) ? 38 : 0;
      set_line_mode(phase[0]);
      phase_items = items_sent + 200;
      while (items_sent < phase_items) begin
        case ($urandom_range(19))
          0: send_tick();
          1: send_item(ACT_START, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), 9'($urandom),
                       1'b0, '0);
          default: random_line();
        endcase
      end
    end
    set_line_mode(1'b0);

    in_ch.valid <= 1'b0;
    wait (pixel_queue.size() == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d transfers over %0d lines in both line modes and four idling",
             items_sent, lines_started);
    $display("phases; checked %0d pixels.", pixels_seen);
    if (failures == 0 && pixel_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
